FILE: src/mecanum_wheel_pi_drive_core_assert.svh
`ifndef MECANUM_WHEEL_PI_DRIVE_CORE_ASSERT_SVH
`define MECANUM_WHEEL_PI_DRIVE_CORE_ASSERT_SVH

// Condition that must hold at every sampled edge out of reset.
`define MWPD_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Condition on the edge after a trigger.
`define MWPD_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

FILE: src/mwpd_pkg.sv
package mwpd_pkg;

	localparam int WHEELS  = 4;
	localparam int VEL_W   = 16;
	localparam int GAIN_W  = 10;
	localparam int ROT_W   = 16;
	localparam int LIMIT_W = 13;
	localparam int CFG_W   = 16;
	localparam int DRIVE_W = 14;

	localparam int PROD_W   = VEL_W + ROT_W + 1;
	localparam int ROT_T_W  = VEL_W + 1;
	localparam int TARGET_W = VEL_W + 3;
	localparam int ERR_W    = TARGET_W + 1;
	localparam int DELTA_W  = ERR_W + 1;
	localparam int PTERM_W  = DELTA_W + GAIN_W + 1;
	localparam int ITERM_W  = ERR_W + GAIN_W + 1;
	localparam int SUM_W    = PTERM_W + 1;

	localparam logic signed [DRIVE_W-1:0] ACCUM_LIMIT = 14'sd7200;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 10'd10;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 10'd10;
	localparam logic [ROT_W-1:0]   ROT_GAIN_RST   = 16'd40534;
	localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST  = 13'd6900;

	typedef enum logic [1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_ROT_GAIN   = 2'd2,
		REG_OUT_LIMIT  = 2'd3
	} cfg_reg_t;

	typedef logic signed [TARGET_W-1:0] target_t;
	typedef logic signed [DRIVE_W-1:0]  accum_t;

	// Stage strobes shared by the lanes and the front end.
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic commit;
	} lane_ctrl_t;

endpackage

FILE: src/mwpd_kinematics.sv
module mwpd_kinematics (
	input  logic                               clk,
	input  mwpd_pkg::lane_ctrl_t               ctrl,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  vel_x,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  vel_y,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  vel_rot,
	input  logic        [mwpd_pkg::ROT_W-1:0]  rotation_gain,
	output mwpd_pkg::target_t                  target [mwpd_pkg::WHEELS]
);
	import mwpd_pkg::*;

	logic signed [VEL_W-1:0]   x_s1;
	logic signed [VEL_W-1:0]   y_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  prod_adj;
	logic signed [ROT_T_W-1:0] rot_t;
	target_t                   x_e;
	target_t                   y_e;
	target_t                   r_e;

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			x_s1    <= vel_x;
			y_s1    <= vel_y;
			prod_s1 <= PROD_W'(vel_rot) * PROD_W'($signed({1'b0, rotation_gain}));
		end
	end

	// truncate toward zero: bias negatives before the shift
	always_comb begin
		prod_adj = prod_s1 + (prod_s1[PROD_W-1] ?
			PROD_W'(signed'(17'sh0FFFF)) : PROD_W'(0));
		rot_t = prod_adj[PROD_W-1:ROT_W];
		x_e   = TARGET_W'(x_s1);
		y_e   = TARGET_W'(y_s1);
		r_e   = TARGET_W'(rot_t);
	end

	assign target[0] = -x_e + y_e + r_e;
	assign target[1] =  x_e + y_e - r_e;
	assign target[2] = -x_e + y_e - r_e;
	assign target[3] =  x_e + y_e + r_e;

endmodule

FILE: src/mwpd_lane.sv
module mwpd_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mwpd_pkg::lane_ctrl_t                ctrl,
	input  logic        [mwpd_pkg::GAIN_W-1:0]  prop_gain,
	input  logic        [mwpd_pkg::GAIN_W-1:0]  integ_gain,
	input  logic signed [mwpd_pkg::VEL_W-1:0]   enc,
	input  mwpd_pkg::target_t                   target,
	output mwpd_pkg::accum_t                    accum_next
);
	import mwpd_pkg::*;

	logic signed [VEL_W-1:0]   enc_s1;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [DELTA_W-1:0] delta_s2;
	logic signed [PTERM_W-1:0] pterm_s3;
	logic signed [ITERM_W-1:0] iterm_s3;
	logic signed [ERR_W-1:0]   err_now;
	logic signed [SUM_W-1:0]   sum;
	accum_t                    accum_q;
	logic signed [ERR_W-1:0]   prev_err_q;

	assign err_now = ERR_W'(enc_s1) - ERR_W'(target);

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			enc_s1 <= enc;
		end
		if (ctrl.load_s2) begin
			err_s2   <= err_now;
			delta_s2 <= DELTA_W'(err_now) - DELTA_W'(prev_err_q);
		end
		if (ctrl.load_s3) begin
			pterm_s3 <= PTERM_W'($signed({1'b0, prop_gain})) * PTERM_W'(delta_s2);
			iterm_s3 <= ITERM_W'($signed({1'b0, integ_gain})) * ITERM_W'(err_s2);
		end
	end

	always_comb begin
		sum = SUM_W'(accum_q) + SUM_W'(pterm_s3) + SUM_W'(iterm_s3);
		priority if (sum > SUM_W'(ACCUM_LIMIT)) begin
			accum_next = ACCUM_LIMIT;
		end else if (sum < -SUM_W'(ACCUM_LIMIT)) begin
			accum_next = -ACCUM_LIMIT;
		end else begin
			accum_next = sum[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			prev_err_q <= '0;
		end else if (ctrl.commit) begin
			accum_q    <= accum_next;
			prev_err_q <= err_s2;
		end
	end

endmodule

FILE: src/mwpd_merge.sv
module mwpd_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                commit,
	input  logic                                out_stall,
	input  logic [mwpd_pkg::LIMIT_W-1:0]        output_limit,
	input  mwpd_pkg::accum_t                    accum [mwpd_pkg::WHEELS],
	output logic                                out_valid,
	output mwpd_pkg::accum_t                    drive [mwpd_pkg::WHEELS]
);
	import mwpd_pkg::*;

	accum_t lim;
	accum_t clipped [WHEELS];
	logic   out_valid_q;
	accum_t drive_q [WHEELS];

	assign lim = DRIVE_W'(output_limit);

	always_comb begin
		for (int i = 0; i < WHEELS; i++) begin
			priority if (accum[i] > lim) begin
				clipped[i] = lim;
			end else if (accum[i] < -lim) begin
				clipped[i] = -lim;
			end else begin
				clipped[i] = accum[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			drive_q <= clipped;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

FILE: src/mecanum_wheel_pi_drive_core.sv
// An accepted word walks v1, v2, v3, then loads the output register and out_valid.
// One word at a time: in_stall is high while a word is in the
//   three-stage lane pipeline (capture and rotation multiply, error, gain multiply).
// Output register lets the next word enter while a finished result waits.
// Reset (arst_n low, asynchronous): gains and limits take their defaults,
//   accumulators and last errors clear to zero, no word in flight.
module mecanum_wheel_pi_drive_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  vel_x,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  vel_y,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  vel_rot,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  enc_front_left,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  enc_front_right,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  enc_rear_left,
	input  logic signed [mwpd_pkg::VEL_W-1:0]  enc_rear_right,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [mwpd_pkg::DRIVE_W-1:0] drive_a,
	output logic signed [mwpd_pkg::DRIVE_W-1:0] drive_b,
	output logic signed [mwpd_pkg::DRIVE_W-1:0] drive_c,
	output logic signed [mwpd_pkg::DRIVE_W-1:0] drive_d,
	// configuration
	input  logic                               cfg_we,
	input  mwpd_pkg::cfg_reg_t                 cfg_index,
	input  logic [mwpd_pkg::CFG_W-1:0]         cfg_data
);
	import mwpd_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0]  prop_gain_q;
	logic [GAIN_W-1:0]  integ_gain_q;
	logic [ROT_W-1:0]   rot_gain_q;
	logic [LIMIT_W-1:0] out_limit_q;

	// one word in flight: a token walks v1 -> v2 -> v3, v3 waits for the output
	logic       v1_q;
	logic       v2_q;
	logic       v3_q;
	logic       accept;
	logic       commit;
	lane_ctrl_t ctrl;

	logic signed [VEL_W-1:0] enc [WHEELS];
	target_t                 target [WHEELS];
	accum_t                  accum_next [WHEELS];
	accum_t                  drive [WHEELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			rot_gain_q   <= ROT_GAIN_RST;
			out_limit_q  <= OUT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_ROT_GAIN:   rot_gain_q   <= cfg_data[ROT_W-1:0];
				REG_OUT_LIMIT:  out_limit_q  <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	assign in_stall = v1_q | v2_q | v3_q;
	assign accept   = in_valid & ~in_stall;
	// the last stage updates lane state only when the output register can load
	assign commit   = v3_q & (~out_valid | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= accept;
			v2_q <= v1_q;
			v3_q <= v2_q | (v3_q & ~commit);
		end
	end

	assign ctrl.load_s1 = accept;
	assign ctrl.load_s2 = v1_q;
	assign ctrl.load_s3 = v2_q;
	assign ctrl.commit  = commit;

	assign enc[0] = enc_front_left;
	assign enc[1] = enc_front_right;
	assign enc[2] = enc_rear_left;
	assign enc[3] = enc_rear_right;

	// shared front end: rotation term and wheel targets
	mwpd_kinematics u_kin (
		.clk           (clk),
		.ctrl          (ctrl),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.vel_rot       (vel_rot),
		.rotation_gain (rot_gain_q),
		.target        (target)
	);

	// one PI lane per wheel
	for (genvar w = 0; w < WHEELS; w++) begin : g_lane
		mwpd_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prop_gain  (prop_gain_q),
			.integ_gain (integ_gain_q),
			.enc        (enc[w]),
			.target     (target[w]),
			.accum_next (accum_next[w])
		);
	end

	// output clip and result register
	mwpd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.out_stall    (out_stall),
		.output_limit (out_limit_q),
		.accum        (accum_next),
		.out_valid    (out_valid),
		.drive        (drive)
	);

	assign drive_a = drive[0];
	assign drive_b = drive[1];
	assign drive_c = drive[2];
	assign drive_d = drive[3];

endmodule

FILE: src/mwpd_checker.sv
`include "mecanum_wheel_pi_drive_core_assert.svh"

module mwpd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [mwpd_pkg::DRIVE_W-1:0] drive_a,
	input logic signed [mwpd_pkg::DRIVE_W-1:0] drive_b,
	input logic signed [mwpd_pkg::DRIVE_W-1:0] drive_c,
	input logic signed [mwpd_pkg::DRIVE_W-1:0] drive_d
);
	import mwpd_pkg::*;

	logic                         drives_in_range;
	logic [WHEELS*DRIVE_W-1:0]    drives_all;

	assign drives_in_range = drive_a <= ACCUM_LIMIT && drive_a >= -ACCUM_LIMIT
		&& drive_b <= ACCUM_LIMIT && drive_b >= -ACCUM_LIMIT
		&& drive_c <= ACCUM_LIMIT && drive_c >= -ACCUM_LIMIT
		&& drive_d <= ACCUM_LIMIT && drive_d >= -ACCUM_LIMIT;
	assign drives_all = {drive_a, drive_b, drive_c, drive_d};

	// one word in the pipeline at a time
	`MWPD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice in a row")

	// drives shown with out_valid never leave the accumulator range
	`MWPD_ASSERT_HOLDS(a_drive_range, !out_valid || drives_in_range, "drive out of range")

	`MWPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	`MWPD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(drives_all), "stalled drive changed")

endmodule

bind mecanum_wheel_pi_drive_core mwpd_checker u_mwpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive_a   (drive_a),
	.drive_b   (drive_b),
	.drive_c   (drive_c),
	.drive_d   (drive_d)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench of the mecanum PI drive core. A scoreboard predicts each drive word from the
// accepted command words. It keeps its own gains, accumulators and last errors for that.
// Directed corner words come first, then randomised phases, each with its own register set.
module tb_top;
	import mwpd_pkg::*;

	// drain margin after the last predicted drive word
	localparam int SETTLE_CYCLES = 8;
	// 2 ms, far beyond the slowest legal run of roughly 650 words
	localparam int TIMEOUT_NS    = 2_000_000;

	typedef logic signed [VEL_W-1:0]   vel_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;
	typedef logic signed [ERR_W-1:0]   err_t;

	// one control tick as it crosses the input channel
	typedef struct packed {
		vel_t vel_x;
		vel_t vel_y;
		vel_t vel_rot;
		vel_t enc_a;
		vel_t enc_b;
		vel_t enc_c;
		vel_t enc_d;
	} tick_t;

	// one drive word, wheels A..D
	typedef struct packed {
		drive_t a;
		drive_t b;
		drive_t c;
		drive_t d;
	} drives_t;

	// Scoreboard: mirrors the register file and the per-wheel PI state, queues the
	// predicted drive words and compares them in order with what comes out.
	class wheel_drive_board;
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [ROT_W-1:0]   rot_gain;
		logic [LIMIT_W-1:0] out_limit;
		drive_t             accum[WHEELS];
		err_t               last_err[WHEELS];
		drives_t            expected_drives[$];
		int                 mismatches;

		function new();
			prop_gain  = PROP_GAIN_RST;
			integ_gain = INTEG_GAIN_RST;
			rot_gain   = ROT_GAIN_RST;
			out_limit  = OUT_LIMIT_RST;
			foreach (accum[w]) begin
				accum[w]    = '0;
				last_err[w] = '0;
			end
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PROP_GAIN:  prop_gain  = val[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain = val[GAIN_W-1:0];
				REG_ROT_GAIN:   rot_gain   = val[ROT_W-1:0];
				REG_OUT_LIMIT:  out_limit  = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		// Z times the Q0.16 lever gain, truncated toward zero
		function longint rot_term(vel_t z);
			longint p;
			p = longint'(z) * longint'(rot_gain);
			return (p < 0) ? -((-p) >>> 16) : (p >>> 16);
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction

		// accepted command word: run the PI step and queue the drive word it gives
		function void note_tick(tick_t t);
			longint x, y, r, err, inc, acc;
			longint target[WHEELS];
			longint enc[WHEELS];
			drive_t out[WHEELS];
			x = longint'(t.vel_x);
			y = longint'(t.vel_y);
			r = rot_term(t.vel_rot);
			target[0] = -x + y + r;
			target[1] =  x + y - r;
			target[2] = -x + y - r;
			target[3] =  x + y + r;
			enc[0] = longint'(t.enc_a);
			enc[1] = longint'(t.enc_b);
			enc[2] = longint'(t.enc_c);
			enc[3] = longint'(t.enc_d);
			for (int w = 0; w < WHEELS; w++) begin
				err = enc[w] - target[w];
				// increment formed at full width, saturated only when added
				inc = longint'(prop_gain) * (err - longint'(last_err[w]))
				    + longint'(integ_gain) * err;
				acc = clamp(longint'(accum[w]) + inc, longint'(ACCUM_LIMIT));
				accum[w]    = drive_t'(acc);
				last_err[w] = err_t'(err);
				out[w]      = drive_t'(clamp(acc, longint'(out_limit)));
			end
			expected_drives.push_back(drives_t'{a: out[0], b: out[1], c: out[2], d: out[3]});
		endfunction

		function void check_drives(drives_t got);
			drives_t want;
			drive_t  g[WHEELS];
			drive_t  e[WHEELS];
			if (expected_drives.size() == 0) begin
				mismatches++;
				$display("%0t: drive word with none expected, got a=%0d b=%0d c=%0d d=%0d",
					$time, got.a, got.b, got.c, got.d);
				return;
			end
			want = expected_drives.pop_front();
			g = '{got.a, got.b, got.c, got.d};
			e = '{want.a, want.b, want.c, want.d};
			for (int w = 0; w < WHEELS; w++)
				if (g[w] !== e[w]) begin
					mismatches++;
					$display("%0t: wheel %c drive expected %0d, got %0d",
						$time, 8'd65 + w, e[w], g[w]);
				end
		endfunction
	endclass

	// ---------------------------------------------------------------------------------
	// DUT inputs start at known values; all later changes are NBAs at rising edges.
	logic             clk             = 1'b0;
	logic             arst_n          = 1'b0;
	logic             in_valid        = 1'b0;
	logic             in_stall;
	vel_t             vel_x           = '0;
	vel_t             vel_y           = '0;
	vel_t             vel_rot         = '0;
	vel_t             enc_front_left  = '0;
	vel_t             enc_front_right = '0;
	vel_t             enc_rear_left   = '0;
	vel_t             enc_rear_right  = '0;
	logic             out_valid;
	logic             out_stall       = 1'b0;
	drive_t           drive_a;
	drive_t           drive_b;
	drive_t           drive_c;
	drive_t           drive_d;
	logic             cfg_we          = 1'b0;
	cfg_reg_t         cfg_index       = REG_PROP_GAIN;
	logic [CFG_W-1:0] cfg_data        = '0;

	// idle rates in percent; dropped to zero for one long unbroken stretch
	int unsigned      send_idle_pct   = 37;
	int unsigned      recv_idle_pct   = 37;

	wheel_drive_board board;

	mecanum_wheel_pi_drive_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.vel_x           (vel_x),
		.vel_y           (vel_y),
		.vel_rot         (vel_rot),
		.enc_front_left  (enc_front_left),
		.enc_front_right (enc_front_right),
		.enc_rear_left   (enc_rear_left),
		.enc_rear_right  (enc_rear_right),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drive_a         (drive_a),
		.drive_b         (drive_b),
		.drive_c         (drive_c),
		.drive_d         (drive_d),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver. Signals read just after the edge still hold their pre-edge values, so a
	// word counts as taken exactly when the DUT saw valid high and stall low.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_drives(drives_t'{a: drive_a, b: drive_b, c: drive_c, d: drive_d});
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// ---------------------------------------------------------------------------------
	// Sender. Valid stays up from one word to the next unless an idle cycle is drawn,
	// and a word is held unchanged while stalled.
	task automatic send_tick(tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{vel_x, vel_y, vel_rot, enc_front_left, enc_front_right, enc_rear_left,
			enc_rear_right} <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_tick(t);
	endtask

	task automatic send_fields(int x, int y, int z, int a, int b, int c, int d);
		send_tick(tick_t'{vel_x: vel_t'(x), vel_y: vel_t'(y), vel_rot: vel_t'(z),
			enc_a: vel_t'(a), enc_b: vel_t'(b), enc_c: vel_t'(c), enc_d: vel_t'(d)});
	endtask

	// stop sending and wait for every predicted drive word, plus a margin
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	// registers change only with the core idle
	task automatic apply_cfg(logic [CFG_W-1:0] p, logic [CFG_W-1:0] i,
		logic [CFG_W-1:0] r, logic [CFG_W-1:0] l);
		settle();
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_ROT_GAIN, r);
		write_reg(REG_OUT_LIMIT, l);
	endtask

	// half the sets use small gains so the accumulators move without pinning
	task automatic random_settings();
		logic [CFG_W-1:0] p;
		logic [CFG_W-1:0] i;
		if ($urandom_range(1)) begin
			p = CFG_W'($urandom_range(15));
			i = CFG_W'($urandom_range(15));
		end else begin
			p = CFG_W'($urandom_range(1023));
			i = CFG_W'($urandom_range(1023));
		end
		apply_cfg(p, i, CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(8191)));
	endtask

	// signed value in the range -2**k to 2**k-1
	function automatic vel_t scaled_vel(int k);
		int v;
		v = int'($urandom_range((1 << (k + 1)) - 1)) - (1 << k);
		return vel_t'(v);
	endfunction

	function automatic vel_t sat_vel(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return vel_t'(v);
	endfunction

	// Mostly wheels that follow their targets with small slip, so the PI loop works
	// inside its range; the rest is scaled or fully random noise.
	function automatic tick_t random_tick();
		tick_t       t;
		int unsigned mode;
		int          k;
		longint      x, y, r;
		mode = $urandom_range(99);
		if (mode < 20) begin
			t.vel_x   = vel_t'($urandom);
			t.vel_y   = vel_t'($urandom);
			t.vel_rot = vel_t'($urandom);
			t.enc_a   = vel_t'($urandom);
			t.enc_b   = vel_t'($urandom);
			t.enc_c   = vel_t'($urandom);
			t.enc_d   = vel_t'($urandom);
		end else if (mode < 45) begin
			t.vel_x   = scaled_vel($urandom_range(15));
			t.vel_y   = scaled_vel($urandom_range(15));
			t.vel_rot = scaled_vel($urandom_range(15));
			t.enc_a   = scaled_vel($urandom_range(15));
			t.enc_b   = scaled_vel($urandom_range(15));
			t.enc_c   = scaled_vel($urandom_range(15));
			t.enc_d   = scaled_vel($urandom_range(15));
		end else begin
			k = $urandom_range(14);
			t.vel_x   = scaled_vel(k);
			t.vel_y   = scaled_vel(k);
			t.vel_rot = scaled_vel(k);
			x = longint'(t.vel_x);
			y = longint'(t.vel_y);
			r = board.rot_term(t.vel_rot);
			t.enc_a = sat_vel(-x + y + r + longint'(scaled_vel($urandom_range(6))));
			t.enc_b = sat_vel( x + y - r + longint'(scaled_vel($urandom_range(6))));
			t.enc_c = sat_vel(-x + y - r + longint'(scaled_vel($urandom_range(6))));
			t.enc_d = sat_vel( x + y + r + longint'(scaled_vel($urandom_range(6))));
		end
		return t;
	endfunction

	task automatic run_random(int n);
		repeat (n)
			send_tick(random_tick());
	endtask

	// ---------------------------------------------------------------------------------
	initial begin
		board = new();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_fields(0, 0, 0, 0, 0, 0, 0);
		send_fields(32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_fields(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_fields(32767, 0, 0, 0, 0, 0, 0);
		send_fields(0, 0, 32767, 0, 0, 0, 0);
		send_fields(0, 0, -32768, 0, 0, 0, 0);
		send_fields(-32768, -32768, -32768, 32767, 32767, 32767, 32767);
		send_fields(5, -7, 100, -3, 12, 0, 1);

		// full gains and huge errors: increment far outside 14 bits must not wrap;
		// limit above the accumulator range leaves the output at +-7200
		apply_cfg(1023, 1023, 65535, 8191);
		send_fields(-32768, -32768, -32768, 32767, 32767, 32767, 32767);
		send_fields(32767, 32767, 32767, -32768, -32768, -32768, -32768);
		send_fields(0, 0, 0, 1, -1, 1, -1);
		apply_cfg(1023, 1023, 65535, 7201);
		send_fields(-32768, 32767, -32768, 32767, -32768, 32767, -32768);
		send_fields(32767, -32768, 32767, -32768, 32767, -32768, 32767);

		// zero limit: drive pinned at zero while the accumulators keep running
		apply_cfg(3, 2, 40534, 0);
		send_fields(10, 20, 30, 400, -400, 200, -200);
		send_fields(-10, 5, -30, 100, 50, -25, 12);
		send_fields(0, 0, 0, 1000, 1000, -1000, -1000);

		// zero gains: accumulators hold what the zero-limit phase left behind
		apply_cfg(0, 0, 0, 7200);
		send_fields(1234, -4321, 999, 7, -7, 77, -77);
		send_fields(0, 0, 0, 0, 0, 0, 0);

		// random phases: corner register sets first, then random ones;
		// phase 6 runs long with no idling on either side
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: apply_cfg(0, 0, 0, 0);
				1: apply_cfg(1023, 1023, 65535, 8191);
				2: apply_cfg(1, 1, 40534, 7200);
				3: apply_cfg(0, 1023, 65535, 1);
				4: apply_cfg(1023, 0, 1, 6900);
				default: random_settings();
			endcase
			if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				run_random(120);
				send_idle_pct = 37;
				recv_idle_pct = 37;
			end else begin
				run_random(44);
			end
		end

		settle();
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/mwpd_pkg.sv
src/mwpd_kinematics.sv
src/mwpd_lane.sv
src/mwpd_merge.sv
src/mecanum_wheel_pi_drive_core.sv
src/mwpd_checker.sv
dv/tb_top.sv
